// File: hdl/simplex_noise_2d_top_assert.svh
// Assertion macros shared by the noise pipeline.
`ifndef SIMPLEX_NOISE_2D_TOP_ASSERT_SVH
`define SIMPLEX_NOISE_2D_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SND_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SND_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/snoise2d_pkg.sv
`default_nettype none
package snoise2d_pkg;

  localparam int IFB = 28;

  localparam logic signed [29:0] SKEW_Q30 = 30'sd393016785;
  localparam logic signed [31:0] USK_Q    = -32'sd56727087;
  localparam logic signed [31:0] ONE_Q    = 32'sd268435456;
  localparam logic signed [31:0] D1_Q     = 32'sd154981282;  // one + 2u
  localparam logic signed [31:0] U_ONE_Q  = 32'sd211708369;  // u + one
  localparam logic signed [31:0] U3_ONE_Q = 32'sd98254195;   // 3u + one
  localparam logic signed [31:0] U3_TWO_Q = 32'sd366689651;  // 3u + 2*one
  localparam logic signed [28:0] RAD_SQ_Q = 29'sd178956971;

  localparam logic [63:0] LAT_PX   = 64'd5910200641878280303;
  localparam logic [63:0] LAT_PY   = 64'd6452764530575939509;
  localparam logic [63:0] HASH_MUL = 64'd6026932503003350773;
  localparam int          HASH_SHIFT = 58;

  localparam int GRAD_SLOTS  = 128;
  localparam int GRAD_IDX_W  = $clog2(GRAD_SLOTS);
  localparam int GRAD_COUNT  = 24;
  localparam int TERM_W      = 37;

  typedef enum logic [1:0] {
    LAT_ZERO,
    LAT_PLUS,
    LAT_TWO,
    LAT_MINUS
  } lat_step_e;

  localparam logic signed [21:0] GRAD_X [GRAD_COUNT] = '{
    22'sd457500, 22'sd1104503, 22'sd1104503, 22'sd457500,
    -22'sd457500, -22'sd1104503, -22'sd1104503, -22'sd457500,
    22'sd156045, 22'sd727777, 22'sd948458, 22'sd1185278,
    22'sd1185278, 22'sd948458, 22'sd727777, 22'sd156045,
    -22'sd156045, -22'sd727777, -22'sd948458, -22'sd1185278,
    -22'sd1185278, -22'sd948458, -22'sd727777, -22'sd156045
  };

  localparam logic signed [21:0] GRAD_Y [GRAD_COUNT] = '{
    22'sd1104503, 22'sd457500, -22'sd457500, -22'sd1104503,
    -22'sd1104503, -22'sd457500, 22'sd457500, 22'sd1104503,
    22'sd1185278, 22'sd948458, 22'sd727777, 22'sd156045,
    -22'sd156045, -22'sd727777, -22'sd948458, -22'sd1185278,
    -22'sd1185278, -22'sd948458, -22'sd727777, -22'sd156045,
    22'sd156045, 22'sd727777, 22'sd948458, 22'sd1185278
  };

  // Lattice offset in multiples of a prime, modulo 2^64.
  function automatic logic [63:0] lat_off(lat_step_e step, logic [63:0] prime);
    logic [63:0] res;
    unique case (step)
      LAT_ZERO:  res = '0;
      LAT_PLUS:  res = prime;
      LAT_TWO:   res = {prime[62:0], 1'b0};
      LAT_MINUS: res = -prime;
      default:   res = '0;
    endcase
    return res;
  endfunction

  // Slot index modulo 24: split as 8*(idx/8 mod 3) + idx mod 8.
  function automatic logic [4:0] grad_index(logic [GRAD_IDX_W-1:0] idx);
    logic [1:0] m;
    case (idx[6:3]) inside
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: m = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       m = 2'd1;
      default:                              m = 2'd2;
    endcase
    return {m, idx[2:0]};
  endfunction

endpackage
`default_nettype wire

// File: hdl/snoise2d_mul64.sv
`default_nettype none
module snoise2d_mul64 (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic      [63:0] prod_o
);

  logic [63:0] ll_d, ll_q;
  logic [31:0] lh_d, lh_q, hl_d, hl_q;
  logic [63:0] prod_d, prod_q;

  // Low 64 bits only: the high-by-high partial product drops out.
  assign ll_d   = {32'b0, a_i[31:0]} * {32'b0, b_i[31:0]};
  assign lh_d   = a_i[31:0] * b_i[63:32];
  assign hl_d   = a_i[63:32] * b_i[31:0];
  assign prod_d = ll_q + {lh_q + hl_q, 32'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q   <= ll_d;
      lh_q   <= lh_d;
      hl_q   <= hl_d;
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// File: hdl/snoise2d_vertex.sv
`default_nettype none
module snoise2d_vertex (
  input  wire logic                                     clk_i,
  input  wire logic                                     en_i,
  input  wire logic                              [63:0] key_i,
  input  wire logic signed                       [31:0] dx_i,
  input  wire logic signed                       [31:0] dy_i,
  output logic signed [snoise2d_pkg::TERM_W-1:0]        term_o
);

  localparam int IW = snoise2d_pkg::GRAD_IDX_W;

  logic [63:0] hash;

  // stage 1: hash multiply, squared offsets
  logic signed [63:0] sqx_d, sqx_q, sqy_d, sqy_q;
  logic signed [31:0] dx1_q, dy1_q;
  // stage 2: falloff base
  logic signed [36:0] a_full;
  logic               pos2_d, pos2_q;
  logic        [27:0] a_q;
  logic signed [31:0] dx2_q, dy2_q;
  // stage 3: gradient products, a squared
  logic [IW-1:0]      slot;
  logic [4:0]         gsel;
  logic signed [53:0] px_d, px_q, py_d, py_q;
  logic        [55:0] aa_d, aa_q;
  logic               pos3_q;
  // stage 4: dot product, a to the fourth
  logic signed [37:0] pxs, pys;
  logic signed [38:0] dot_full;
  logic signed [35:0] dot_d, dot_q;
  logic        [27:0] a2;
  logic        [55:0] a4p_d, a4p_q;
  logic               pos4_q;
  // stage 5: weighted term
  logic signed [64:0] termp_d, termp_q;
  logic               pos5_q;

  snoise2d_mul64 u_hash_mul (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .a_i    (key_i),
    .b_i    (snoise2d_pkg::HASH_MUL),
    .prod_o (hash)
  );

  assign sqx_d = dx_i * dx_i;
  assign sqy_d = dy_i * dy_i;

  assign a_full = 37'(snoise2d_pkg::RAD_SQ_Q) - $signed({1'b0, sqx_q[63:28]})
                - $signed({1'b0, sqy_q[63:28]});
  assign pos2_d = !a_full[36] && (a_full != '0);

  // Fold the xor-shift into the slot bits.
  assign slot = hash[IW:1] ^ IW'(hash >> (snoise2d_pkg::HASH_SHIFT + 1));
  assign gsel = snoise2d_pkg::grad_index(slot);
  assign px_d = snoise2d_pkg::GRAD_X[gsel] * dx2_q;
  assign py_d = snoise2d_pkg::GRAD_Y[gsel] * dy2_q;
  assign aa_d = {28'b0, a_q} * {28'b0, a_q};

  assign pxs      = px_q[53:16];
  assign pys      = py_q[53:16];
  assign dot_full = 39'(pxs) + 39'(pys);
  assign dot_d    = dot_full[35:0];
  assign a2       = aa_q[55:28];
  assign a4p_d    = {28'b0, a2} * {28'b0, a2};

  assign termp_d = $signed({1'b0, a4p_q[55:28]}) * dot_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q   <= sqx_d;
      sqy_q   <= sqy_d;
      dx1_q   <= dx_i;
      dy1_q   <= dy_i;
      a_q     <= a_full[27:0];
      pos2_q  <= pos2_d;
      dx2_q   <= dx1_q;
      dy2_q   <= dy1_q;
      px_q    <= px_d;
      py_q    <= py_d;
      aa_q    <= aa_d;
      pos3_q  <= pos2_q;
      dot_q   <= dot_d;
      a4p_q   <= a4p_d;
      pos4_q  <= pos3_q;
      termp_q <= termp_d;
      pos5_q  <= pos4_q;
    end
  end

  // Drop vertices out of reach.
  assign term_o = pos5_q ? termp_q[64:28] : '0;

endmodule
`default_nettype wire

// File: hdl/simplex_noise_2d_top.sv
// Throughput: one transaction per cycle; the whole pipeline advances together
// and freezes only while a held result is stalled.
// The 64-bit multiplies are split over two stages of 32-bit partial products.
// Reset (asynchronous, active low) clears the stage valid bits only.
`default_nettype none
module simplex_noise_2d_top #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic        [63:0] seed_i,
  input  wire logic signed [31:0] x_coord_i,
  input  wire logic signed [31:0] y_coord_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed      [19:0] noise_value_o
);

  `include "simplex_noise_2d_top_assert.svh"

  localparam int SB  = COORD_FRAC_BITS + 30;
  localparam int NS  = 11;
  localparam int OSH = snoise2d_pkg::IFB - OUT_FRAC_BITS;
  localparam int TW  = snoise2d_pkg::TERM_W;
  localparam logic signed [38:0] OUT_MAX = 39'sd524287;
  localparam logic signed [38:0] OUT_MIN = -39'sd524288;

  logic          en;
  logic [NS-1:0] vld_d, vld_q;

  // stage 1
  logic signed [32:0] sxy;
  logic signed [61:0] skew_d, skew_q;
  logic        [63:0] seed1_q;
  logic signed [31:0] x1_q, y1_q;
  // stage 2
  logic signed [63:0] xs_d, xs_q, ys_d, ys_q;
  logic        [63:0] seed2_q;
  // stage 3
  logic        [63:0] xsb, ysb;
  logic        [27:0] xi_d, yi_d, xi_q, yi_q;
  logic        [28:0] xy_sum;
  logic signed [56:0] tprod_d, tprod_q;
  logic        [63:0] seed3_q;
  // stage 4
  logic        [63:0] xp, yp;
  logic signed [28:0] t;
  logic signed [31:0] dx0, dy0;
  logic signed [30:0] x2my, y2mx;
  logic signed [31:0] dx_d [4];
  logic signed [31:0] dy_d [4];
  logic signed [31:0] dx_q [4];
  logic signed [31:0] dy_q [4];
  snoise2d_pkg::lat_step_e kx_d [4];
  snoise2d_pkg::lat_step_e ky_d [4];
  snoise2d_pkg::lat_step_e kx_q [4];
  snoise2d_pkg::lat_step_e ky_q [4];
  logic        [63:0] seed4_q;
  logic        [63:0] key [4];
  logic signed [TW-1:0] term [4];
  // stages 10 and 11
  logic signed [38:0] sum_d, sum_q, shifted;
  logic signed [19:0] noise_d, noise_q;

  assign en         = !(vld_q[NS-1] && out_stall_i);
  assign in_stall_o = !en;
  assign vld_d      = {vld_q[NS-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // Skew.
  assign sxy    = 33'(x_coord_i) + 33'(y_coord_i);
  assign skew_d = sxy * snoise2d_pkg::SKEW_Q30;
  assign xs_d   = 64'($signed({x1_q, 30'b0})) + 64'(skew_q);
  assign ys_d   = 64'($signed({y1_q, 30'b0})) + 64'(skew_q);

  // Floor to the lattice, keep a Q28 fraction.
  assign xsb     = {{SB{xs_q[63]}}, xs_q[63:SB]};
  assign ysb     = {{SB{ys_q[63]}}, ys_q[63:SB]};
  assign xi_d    = xs_q[SB-1 -: 28];
  assign yi_d    = ys_q[SB-1 -: 28];
  assign xy_sum  = {1'b0, xi_d} + {1'b0, yi_d};
  assign tprod_d = $signed({1'b0, xy_sum}) * 27'(snoise2d_pkg::USK_Q);

  snoise2d_mul64 u_lat_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (xsb),
    .b_i    (snoise2d_pkg::LAT_PX),
    .prod_o (xp)
  );

  snoise2d_mul64 u_lat_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (ysb),
    .b_i    (snoise2d_pkg::LAT_PY),
    .prod_o (yp)
  );

  assign t    = tprod_q[56:28];
  assign dx0  = $signed({4'b0, xi_q}) + 32'(t);
  assign dy0  = $signed({4'b0, yi_q}) + 32'(t);
  assign x2my = $signed({2'b0, xi_q, 1'b0}) - $signed({3'b0, yi_q});
  assign y2mx = $signed({2'b0, yi_q, 1'b0}) - $signed({3'b0, xi_q});

  // Pick the four vertices of the cell.
  always_comb begin
    dx_d[0] = dx0;
    dy_d[0] = dy0;
    kx_d[0] = snoise2d_pkg::LAT_ZERO;
    ky_d[0] = snoise2d_pkg::LAT_ZERO;
    dx_d[1] = dx0 - snoise2d_pkg::D1_Q;
    dy_d[1] = dy0 - snoise2d_pkg::D1_Q;
    kx_d[1] = snoise2d_pkg::LAT_PLUS;
    ky_d[1] = snoise2d_pkg::LAT_PLUS;
    if (32'(t) < snoise2d_pkg::USK_Q) begin
      if (32'(x2my) > snoise2d_pkg::ONE_Q) begin
        dx_d[2] = dx0 - snoise2d_pkg::U3_TWO_Q;
        dy_d[2] = dy0 - snoise2d_pkg::U3_ONE_Q;
        kx_d[2] = snoise2d_pkg::LAT_TWO;
        ky_d[2] = snoise2d_pkg::LAT_PLUS;
      end else begin
        dx_d[2] = dx0 - snoise2d_pkg::USK_Q;
        dy_d[2] = dy0 - snoise2d_pkg::U_ONE_Q;
        kx_d[2] = snoise2d_pkg::LAT_ZERO;
        ky_d[2] = snoise2d_pkg::LAT_PLUS;
      end
      if (32'(y2mx) > snoise2d_pkg::ONE_Q) begin
        dx_d[3] = dx0 - snoise2d_pkg::U3_ONE_Q;
        dy_d[3] = dy0 - snoise2d_pkg::U3_TWO_Q;
        kx_d[3] = snoise2d_pkg::LAT_PLUS;
        ky_d[3] = snoise2d_pkg::LAT_TWO;
      end else begin
        dx_d[3] = dx0 - snoise2d_pkg::U_ONE_Q;
        dy_d[3] = dy0 - snoise2d_pkg::USK_Q;
        kx_d[3] = snoise2d_pkg::LAT_PLUS;
        ky_d[3] = snoise2d_pkg::LAT_ZERO;
      end
    end else begin
      if (x2my[30]) begin
        dx_d[2] = dx0 + snoise2d_pkg::U_ONE_Q;
        dy_d[2] = dy0 + snoise2d_pkg::USK_Q;
        kx_d[2] = snoise2d_pkg::LAT_MINUS;
        ky_d[2] = snoise2d_pkg::LAT_ZERO;
      end else begin
        dx_d[2] = dx0 - snoise2d_pkg::U_ONE_Q;
        dy_d[2] = dy0 - snoise2d_pkg::USK_Q;
        kx_d[2] = snoise2d_pkg::LAT_PLUS;
        ky_d[2] = snoise2d_pkg::LAT_ZERO;
      end
      if (y2mx[30]) begin
        dx_d[3] = dx0 + snoise2d_pkg::USK_Q;
        dy_d[3] = dy0 + snoise2d_pkg::U_ONE_Q;
        kx_d[3] = snoise2d_pkg::LAT_ZERO;
        ky_d[3] = snoise2d_pkg::LAT_MINUS;
      end else begin
        dx_d[3] = dx0 - snoise2d_pkg::USK_Q;
        dy_d[3] = dy0 - snoise2d_pkg::U_ONE_Q;
        kx_d[3] = snoise2d_pkg::LAT_ZERO;
        ky_d[3] = snoise2d_pkg::LAT_PLUS;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      seed1_q <= seed_i;
      x1_q    <= x_coord_i;
      y1_q    <= y_coord_i;
      skew_q  <= skew_d;
      seed2_q <= seed1_q;
      xs_q    <= xs_d;
      ys_q    <= ys_d;
      seed3_q <= seed2_q;
      xi_q    <= xi_d;
      yi_q    <= yi_d;
      tprod_q <= tprod_d;
      seed4_q <= seed3_q;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      kx_q    <= kx_d;
      ky_q    <= ky_d;
      sum_q   <= sum_d;
      noise_q <= noise_d;
    end
  end

  for (genvar v = 0; v < 4; v++) begin : g_vertex
    assign key[v] = seed4_q
                  ^ (xp + snoise2d_pkg::lat_off(kx_q[v], snoise2d_pkg::LAT_PX))
                  ^ (yp + snoise2d_pkg::lat_off(ky_q[v], snoise2d_pkg::LAT_PY));

    snoise2d_vertex u_vertex (
      .clk_i  (clk_i),
      .en_i   (en),
      .key_i  (key[v]),
      .dx_i   (dx_q[v]),
      .dy_i   (dy_q[v]),
      .term_o (term[v])
    );
  end

  assign sum_d = 39'(term[0]) + 39'(term[1]) + 39'(term[2]) + 39'(term[3]);

  // Scale down and clamp.
  assign shifted = sum_q >>> OSH;
  always_comb begin
    if (shifted > OUT_MAX) begin
      noise_d = 20'(OUT_MAX);
    end else if (shifted < OUT_MIN) begin
      noise_d = 20'(OUT_MIN);
    end else begin
      noise_d = shifted[19:0];
    end
  end

  assign out_valid_o   = vld_q[NS-1];
  assign noise_value_o = noise_q;

  `SND_ASSERT_IMP(a_stall_only_on_held_out, clk_i, rst_ni, in_stall_o,
                  out_valid_o && out_stall_i, "input stalled without a held result")
  `SND_ASSERT_NXT(a_accept_enters_pipe, clk_i, rst_ni, in_valid_i && !in_stall_o,
                  vld_q[0], "accepted transaction missing from first stage")
  `SND_ASSERT_NXT(a_last_stage_reaches_out, clk_i, rst_ni, vld_q[NS-2] && en,
                  out_valid_o, "transaction lost before the output register")
  `SND_ASSERT_NXT(a_frozen_pipe_holds, clk_i, rst_ni, in_stall_o,
                  vld_q == $past(vld_q), "valid bits moved while frozen")

endmodule
`default_nettype wire

// File: bench/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CFB = 16;
  localparam int OFB = 16;
  localparam int IFB = 28;
  localparam longint SKEW = 64'sd393016785;
  localparam longint USK = -64'sd56727087;
  localparam longint ONE = 64'sd268435456;
  localparam longint RADSQ = 64'sd178956971;
  localparam logic [63:0] PX = 64'd5910200641878280303;
  localparam logic [63:0] PY = 64'd6452764530575939509;
  localparam logic [63:0] HMUL = 64'd6026932503003350773;
  localparam int LIMIT = 400000;

  typedef struct {
    logic [63:0] seed;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } sample_t;

  localparam longint GA = 457500, GB = 1104503, GC = 156045;
  localparam longint GD = 727777, GE = 948458, GF = 1185278;
  longint grad_x [24] = '{GA, GB, GB, GA, -GA, -GB, -GB, -GA,
                          GC, GD, GE, GF, GF, GE, GD, GC,
                          -GC, -GD, -GE, -GF, -GF, -GE, -GD, -GC};
  longint grad_y [24] = '{GB, GA, -GA, -GB, -GB, -GA, GA, GB,
                          GF, GE, GD, GC, -GC, -GD, -GE, -GF,
                          -GF, -GE, -GD, -GC, GC, GD, GE, GF};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [63:0] seed = '0;
  logic signed [31:0] x_coord = '0;
  logic signed [31:0] y_coord = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [19:0] noise_value;

  sample_t pending[$];
  logic signed [19:0] expected_noise[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;
  bit in_taken = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  simplex_noise_2d_top i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .seed_i(seed), .x_coord_i(x_coord), .y_coord_i(y_coord),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .noise_value_o(noise_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // >>> on longint is arithmetic, so it floors
  function automatic longint vertex_noise(logic [63:0] s, logic [63:0] xp,
                                          logic [63:0] yp, longint dx, longint dy);
    longint a, dot, a2, a4;
    logic [63:0] h;
    int g;
    a = RADSQ - ((dx * dx) >>> IFB) - ((dy * dy) >>> IFB);
    if (a <= 0) return 0;
    h = (s ^ xp ^ yp) * HMUL;
    h = h ^ (h >> 58);
    g = int'((h >> 1) & 64'd127) % 24;
    dot = ((grad_x[g] * dx) >>> 16) + ((grad_y[g] * dy) >>> 16);
    a2 = (a * a) >>> IFB;
    a4 = (a2 * a2) >>> IFB;
    return (a4 * dot) >>> IFB;
  endfunction

  function automatic logic signed [19:0] noise_at(sample_t it);
    longint x, y, sk, xs, ys, xsb, ysb, xi, yi, t, dx0, dy0, d1, xmy, sum, r;
    logic [63:0] xp, yp, fmask;
    x = longint'(it.x);
    y = longint'(it.y);
    fmask = (64'd1 << (CFB + 30)) - 1;
    sk = (x + y) * SKEW;
    xs = x * (64'sd1 <<< 30) + sk;
    ys = y * (64'sd1 <<< 30) + sk;
    xsb = xs >>> (CFB + 30);
    ysb = ys >>> (CFB + 30);
    xi = longint'((xs & fmask) >> (CFB + 2));
    yi = longint'((ys & fmask) >> (CFB + 2));
    xp = xsb * PX;
    yp = ysb * PY;
    t = ((xi + yi) * USK) >>> IFB;
    dx0 = xi + t;
    dy0 = yi + t;
    d1 = ONE + 2 * USK;
    xmy = xi - yi;
    sum = vertex_noise(it.seed, xp, yp, dx0, dy0);
    sum += vertex_noise(it.seed, xp + PX, yp + PY, dx0 - d1, dy0 - d1);
    if (t < USK) begin
      if (xi + xmy > ONE)
        sum += vertex_noise(it.seed, xp + (PX << 1), yp + PY,
                            dx0 - (3 * USK + 2 * ONE), dy0 - (3 * USK + ONE));
      else
        sum += vertex_noise(it.seed, xp, yp + PY, dx0 - USK, dy0 - (USK + ONE));
      if (yi - xmy > ONE)
        sum += vertex_noise(it.seed, xp + PX, yp + (PY << 1),
                            dx0 - (3 * USK + ONE), dy0 - (3 * USK + 2 * ONE));
      else
        sum += vertex_noise(it.seed, xp + PX, yp, dx0 - (USK + ONE), dy0 - USK);
    end else begin
      if (xi + xmy < 0)
        sum += vertex_noise(it.seed, xp - PX, yp, dx0 + (ONE + USK), dy0 + USK);
      else
        sum += vertex_noise(it.seed, xp + PX, yp, dx0 - (USK + ONE), dy0 - USK);
      if (yi < xmy)
        sum += vertex_noise(it.seed, xp, yp - PY, dx0 + USK, dy0 + (USK + ONE));
      else
        sum += vertex_noise(it.seed, xp, yp + PY, dx0 - USK, dy0 - (USK + ONE));
    end
    r = sum >>> (IFB - OFB);
    if (r > 524287) r = 524287;
    if (r < -524288) r = -524288;
    return r[19:0];
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 50) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 20 << CFB)) - (10 << CFB));
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return 32'(int'($urandom_range(0, 400)) * 32'sd16384 - 32'sd3276800);
    endcase
  endfunction

  // Drive at the falling edge; hold the payload until the last rising edge took it.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
      end else if (in_gap > 0 || hold_off || pending.size() == 0) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else begin
        seed <= pending[0].seed;
        x_coord <= pending[0].x;
        y_coord <= pending[0].y;
        expected_noise.push_back(noise_at(pending[0]));
        void'(pending.pop_front());
        in_valid <= 1'b1;
        in_gap <= gap_len();
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap <= out_gap - 1;
      end else begin
        out_stall <= 1'b0;
        out_gap <= gap_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_noise.size() == 0) begin
        $error("noise_value: result with no transaction pending, actual %0d",
               noise_value);
        errors++;
      end else begin
        if (noise_value !== expected_noise[0]) begin
          $error("noise_value: expected %0d actual %0d", expected_noise[0], noise_value);
          errors++;
        end
        void'(expected_noise.pop_front());
      end
    end
  end

  // Drained once nothing waits in the driver or on the port and the expectation
  // queue is empty; the one on the port is already in that queue.
  function automatic bit all_drained();
    return pending.size() == 0 && !in_valid && expected_noise.size() == 0;
  endfunction

  initial begin
    sample_t it;
    logic [31:0] edges [6];
    edges = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
              32'h00010000, 32'h00008000};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (edges[i]) begin
      it.seed = (i % 2) ? '1 : '0;
      it.x = edges[i];
      it.y = edges[5 - i];
      pending.push_back(it);
    end
    for (int i = 0; i < 12; i++) begin
      it.seed = 64'h1 << (i * 5);
      it.x = 32'(i * 9000);
      it.y = 32'(i * 21000 - 40000);
      pending.push_back(it);
    end
    it.seed = 64'h8000000000000000; it.x = 32'sh7fff0000; it.y = 32'sh80010000;
    pending.push_back(it);
    while (!all_drained()) @(posedge clk);
    hold_off = 1'b1;
    repeat (20) @(posedge clk);
    hold_off = 1'b0;
    for (int i = 0; i < 1500; i++) begin
      it.seed = {$urandom, $urandom};
      it.x = rand_coord();
      it.y = rand_coord();
      pending.push_back(it);
    end
    while (!all_drained()) @(posedge clk);
    repeat (20) @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    while (!stim_done && cycles < LIMIT) @(posedge clk);
    if (stim_done && errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
